>>> hw/rtl/dqsb_pkg.sv
package dqsb_pkg;

    localparam int DEFAULT_DEPTH = 16;
    localparam int DATA_W        = 32;
    localparam int CMD_DEPTH     = 2;

    // request codes on the func port
    localparam logic [1:0] FUNC_ENQ_ONE = 2'd0;
    localparam logic [1:0] FUNC_ENQ_TWO = 2'd1;
    localparam logic [1:0] FUNC_DEQ_ONE = 2'd2;
    localparam logic [1:0] FUNC_DEQ_TWO = 2'd3;

    // result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        OP_ENQ_ONE,
        OP_ENQ_TWO,
        OP_DEQ_ONE,
        OP_DEQ_TWO
    } op_t;

    typedef struct packed {
        op_t                      op;
        logic signed [DATA_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

>>> hw/rtl/dqsb_front.sv
module dqsb_front
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         func,
    input  logic signed [dqsb_pkg::DATA_W-1:0] value,
    input  dqsb_pkg::fifo_status_t             fifo_status,
    output logic                               push,
    output dqsb_pkg::cmd_t                     cmd
);

    logic           valid_reg;
    logic           valid_next;
    dqsb_pkg::cmd_t cmd_reg;
    dqsb_pkg::cmd_t cmd_next;
    logic           accept;

    assign busy   = valid_reg & fifo_status.full;
    assign push   = valid_reg & ~fifo_status.full;
    assign accept = start & ~busy;
    assign cmd    = cmd_reg;

    always_comb
    begin
        cmd_next.value = value;
        unique case (func)
            dqsb_pkg::FUNC_ENQ_ONE: cmd_next.op = dqsb_pkg::OP_ENQ_ONE;
            dqsb_pkg::FUNC_ENQ_TWO: cmd_next.op = dqsb_pkg::OP_ENQ_TWO;
            dqsb_pkg::FUNC_DEQ_ONE: cmd_next.op = dqsb_pkg::OP_DEQ_ONE;
            default:                cmd_next.op = dqsb_pkg::OP_DEQ_TWO;
        endcase
    end

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

>>> hw/rtl/dqsb_cmd_fifo.sv
module dqsb_cmd_fifo
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  dqsb_pkg::cmd_t         push_cmd,
    input  logic                   pop,
    output dqsb_pkg::cmd_t         pop_cmd,
    output dqsb_pkg::fifo_status_t status
);

    localparam int PTR_W = (dqsb_pkg::CMD_DEPTH > 1) ? $clog2(dqsb_pkg::CMD_DEPTH) : 1;
    localparam int CNT_W = $clog2(dqsb_pkg::CMD_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(dqsb_pkg::CMD_DEPTH);
    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(dqsb_pkg::CMD_DEPTH - 1);

    dqsb_pkg::cmd_t   entries [dqsb_pkg::CMD_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign status.full  = (count_reg == CNT_MAX);
    assign status.empty = (count_reg == '0);
    assign do_push      = push & ~status.full;
    assign do_pop       = pop & ~status.empty;
    assign pop_cmd      = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_MAX) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_MAX) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> hw/rtl/dqsb_back.sv
module dqsb_back
#(
    parameter int DEPTH = dqsb_pkg::DEFAULT_DEPTH
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  dqsb_pkg::fifo_status_t             fifo_status,
    input  dqsb_pkg::cmd_t                     cmd,
    output logic                               pop,
    output logic                               done,
    output logic signed [dqsb_pkg::DATA_W-1:0] data,
    output logic [1:0]                         status
);

    localparam int PW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PW-1:0] TOP      = PW'(DEPTH);
    localparam logic [PW-1:0] TOP_LAST = PW'(DEPTH - 1);

    // queue one pointers are kept plus one so that the empty marker is zero
    logic [PW-1:0] h1_reg, h1_next;
    logic [PW-1:0] t1_reg, t1_next;
    logic [PW-1:0] h2_reg, h2_next;
    logic [PW-1:0] t2_reg, t2_next;

    logic signed [dqsb_pkg::DATA_W-1:0] mem [DEPTH];
    logic signed [dqsb_pkg::DATA_W-1:0] rd_data_reg;

    logic          done_reg;
    logic [1:0]    status_reg, status_next;
    logic          deq_ok_reg, deq_ok_next;
    logic          full;
    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;

    assign pop  = ~fifo_status.empty;
    // t1_reg already holds tail one plus one
    assign full = (t1_reg == t2_reg);

    always_comb
    begin
        h1_next     = h1_reg;
        t1_next     = t1_reg;
        h2_next     = h2_reg;
        t2_next     = t2_reg;
        status_next = dqsb_pkg::ST_DONE;
        deq_ok_next = 1'b0;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        wr_addr     = t1_reg[AW-1:0];
        rd_addr     = h2_reg[AW-1:0];
        unique case (cmd.op)
            dqsb_pkg::OP_ENQ_ONE:
            begin
                if (full || t1_reg == TOP)
                begin
                    status_next = dqsb_pkg::ST_FULL;
                end
                else
                begin
                    if (h1_reg == '0)
                    begin
                        h1_next = PW'(1);
                    end
                    t1_next = t1_reg + 1'b1;
                    wr_en   = pop;
                    wr_addr = t1_reg[AW-1:0];
                end
            end
            dqsb_pkg::OP_ENQ_TWO:
            begin
                if (full || t2_reg == '0)
                begin
                    status_next = dqsb_pkg::ST_FULL;
                end
                else
                begin
                    if (h2_reg == TOP)
                    begin
                        h2_next = TOP_LAST;
                    end
                    t2_next = t2_reg - 1'b1;
                    wr_en   = pop;
                    wr_addr = t2_next[AW-1:0];
                end
            end
            dqsb_pkg::OP_DEQ_ONE:
            begin
                if (h1_reg == '0)
                begin
                    status_next = dqsb_pkg::ST_EMPTY;
                end
                else
                begin
                    deq_ok_next = 1'b1;
                    rd_en       = pop;
                    rd_addr     = AW'(h1_reg - 1'b1);
                    if (h1_reg == t1_reg)
                    begin
                        h1_next = '0;
                        t1_next = '0;
                    end
                    else
                    begin
                        h1_next = h1_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                if (h2_reg == TOP)
                begin
                    status_next = dqsb_pkg::ST_EMPTY;
                end
                else
                begin
                    deq_ok_next = 1'b1;
                    rd_en       = pop;
                    rd_addr     = h2_reg[AW-1:0];
                    if (h2_reg == t2_reg)
                    begin
                        h2_next = TOP;
                        t2_next = TOP;
                    end
                    else
                    begin
                        h2_next = h2_reg - 1'b1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h1_reg     <= '0;
            t1_reg     <= '0;
            h2_reg     <= TOP;
            t2_reg     <= TOP;
            done_reg   <= 1'b0;
            status_reg <= dqsb_pkg::ST_DONE;
            deq_ok_reg <= 1'b0;
        end
        else
        begin
            done_reg <= pop;
            if (pop)
            begin
                h1_reg     <= h1_next;
                t1_reg     <= t1_next;
                h2_reg     <= h2_next;
                t2_reg     <= t2_next;
                status_reg <= status_next;
                deq_ok_reg <= deq_ok_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= cmd.value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign done   = done_reg;
    assign status = status_reg;
    assign data   = deq_ok_reg ? rd_data_reg : '0;

endmodule

>>> hw/rtl/dual_queue_shared_buffer.sv
// channel   ports                  transfer
// request   start, func, value     start high and busy low at a rising edge
// result    done, data, status     done high for one cycle, taken at its closing edge
//
// requests pass the front register and command queue; the back stage registers each result
// one request per cycle sustained while busy is low; the back stage updates pointers and
// does one buffer access per cycle, with the read word registered out of the buffer memory
// busy rises only when the front register and the command queue are both full
// rst_n clears all pointers to empty and drops done; buffer contents are not cleared
// the receiver cannot stall, so results never back up into the block
module dual_queue_shared_buffer
#(
    parameter int DEPTH = dqsb_pkg::DEFAULT_DEPTH
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         func,
    input  logic signed [dqsb_pkg::DATA_W-1:0] value,
    output logic                               done,
    output logic signed [dqsb_pkg::DATA_W-1:0] data,
    output logic [1:0]                         status
);

    dqsb_pkg::fifo_status_t fifo_status;
    dqsb_pkg::cmd_t         push_cmd;
    dqsb_pkg::cmd_t         pop_cmd;
    logic                   push;
    logic                   pop;

    dqsb_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .value       (value),
        .fifo_status (fifo_status),
        .push        (push),
        .cmd         (push_cmd)
    );

    dqsb_cmd_fifo u_cmd_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .status   (fifo_status)
    );

    dqsb_back #(.DEPTH(DEPTH)) u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .fifo_status (fifo_status),
        .cmd         (pop_cmd),
        .pop         (pop),
        .done        (done),
        .data        (data),
        .status      (status)
    );

endmodule
